// ----- hw/rtl/wfsa_pkg.sv -----
package wfsa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 32;
  localparam int DATA_W       = 32;
  localparam int OWNER_W      = 16;
  localparam int STATUS_W     = 3;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [DATA_W-1:0]  RESET_TOTAL    = DATA_W'(65536);
  localparam logic [DATA_W-1:0]  RESET_RESERVED = DATA_W'(4096);
  localparam logic [OWNER_W-1:0] RESERVED_OWNER = OWNER_W'(1);
  localparam logic [OWNER_W-1:0] FIRST_OWNER    = OWNER_W'(2);

  localparam logic [STATUS_W-1:0] ST_GRANTED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_TOO_BIG = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_FULL    = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_BAD_CFG = STATUS_W'(4);

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] length;
    logic [OWNER_W-1:0]   owner;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [ADDR_BITS-1:0] hole;
    logic [IDX_W-1:0]     idx;
    logic [ADDR_BITS-1:0] seg_end;
  } tok_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] total;
    logic [CNT_W-1:0]     count;
    logic                 ins_en;
    logic [IDX_W-1:0]     ins_pos;
    entry_t               ins_entry;
    logic                 len0_we;
    logic [ADDR_BITS-1:0] len0;
  } bcast_t;

endpackage

// ----- hw/rtl/wfsa_cell.sv -----
module wfsa_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [wfsa_pkg::IDX_W-1:0]     cell_idx,
  input  wfsa_pkg::bcast_t               bc,
  input  wfsa_pkg::entry_t               left_entry,
  input  logic [wfsa_pkg::ADDR_BITS-1:0] right_base,
  input  wfsa_pkg::tok_t                 tok_in,
  output wfsa_pkg::entry_t               entry,
  output wfsa_pkg::tok_t                 tok_out
);

  wfsa_pkg::entry_t                 entry_r;
  wfsa_pkg::entry_t                 entry_nxt;
  logic [wfsa_pkg::ADDR_BITS-1:0]   end_r;
  logic [wfsa_pkg::ADDR_BITS-1:0]   end_nxt;
  logic [wfsa_pkg::ADDR_BITS-1:0]   hole_r;
  logic [wfsa_pkg::ADDR_BITS-1:0]   hole_nxt;
  logic [wfsa_pkg::ADDR_BITS-1:0]   limit;
  logic [wfsa_pkg::ADDR_BITS:0]     sum;
  logic [wfsa_pkg::CNT_W-1:0]       idx_ext;
  logic                             active;
  logic                             last;
  wfsa_pkg::tok_t                   tok_r;
  wfsa_pkg::tok_t                   tok_nxt;

  assign idx_ext = wfsa_pkg::CNT_W'(cell_idx);
  assign active  = idx_ext < bc.count;
  assign last    = (idx_ext + wfsa_pkg::CNT_W'(1)) == bc.count;

  // Segment end saturates at the all-ones address.
  assign sum     = {1'b0, entry_r.base} + {1'b0, entry_r.length};
  assign end_nxt = sum[wfsa_pkg::ADDR_BITS] ? '1 : sum[wfsa_pkg::ADDR_BITS-1:0];

  assign limit    = last ? bc.total : right_base;
  assign hole_nxt = (limit > end_r) ? (limit - end_r) : '0;

  always_comb begin
    entry_nxt = entry_r;
    if (bc.ins_en) begin
      if (cell_idx == bc.ins_pos) begin
        entry_nxt = bc.ins_entry;
      end else if (cell_idx > bc.ins_pos) begin
        entry_nxt = left_entry;
      end
    end
    if (bc.len0_we && (cell_idx == '0)) begin
      entry_nxt.length = bc.len0;
    end
  end

  // Strictly greater keeps the first of equal holes.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && active && (hole_r > tok_in.hole)) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.hole    = hole_r;
      tok_nxt.idx     = cell_idx;
      tok_nxt.seg_end = end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      if (cell_idx == '0) begin
        entry_r.base   <= '0;
        entry_r.length <= wfsa_pkg::ADDR_BITS'(wfsa_pkg::RESET_RESERVED);
        entry_r.owner  <= wfsa_pkg::RESERVED_OWNER;
      end
    end else begin
      tok_r.valid <= tok_nxt.valid;
      entry_r     <= entry_nxt;
    end
    tok_r.found   <= tok_nxt.found;
    tok_r.hole    <= tok_nxt.hole;
    tok_r.idx     <= tok_nxt.idx;
    tok_r.seg_end <= tok_nxt.seg_end;
    end_r         <= end_nxt;
    hole_r        <= hole_nxt;
  end

  assign entry   = entry_r;
  assign tok_out = tok_r;

endmodule

// ----- hw/rtl/worst_fit_segment_allocator.sv -----
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_request_size
// out_      output     out_valid/out_stall out_status, out_base_address, out_owner_id
// cfg_      input      APB write/read      total_size (0x0), reserved_size (0x4)
//
// A request that passes the checks steps through S_SET1 and S_SET2, while the cell end and
// hole registers settle, then S_LAUNCH, which starts the best-hole token, and S_SCAN, while
// the token hops through the registered row of MAX_SEGMENTS cells; the best hole is compared
// with the size, a granted request is inserted in S_INS, and S_DONE loads the output register.
// A request that finds no hole skips S_INS. Rejections by configuration, size or a full table
// go straight to S_DONE. Synchronous reset restores both registers, the reserved entry and the
// owner counter. A stalled result holds in the output register while the input channel is free
// again; a further result waits until it is taken.
module worst_fit_segment_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_request_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_base_address,
  output logic [15:0]                   out_owner_id,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SET1   = 3'd1;
  localparam logic [2:0] S_SET2   = 3'd2;
  localparam logic [2:0] S_LAUNCH = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_INS    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  localparam int MS = wfsa_pkg::MAX_SEGMENTS;
  localparam int AW = wfsa_pkg::ADDR_BITS;

  logic [2:0]                          state_r;
  logic [2:0]                          state_nxt;
  logic [wfsa_pkg::DATA_W-1:0]         total_r;
  logic [wfsa_pkg::DATA_W-1:0]         reserved_r;
  logic [wfsa_pkg::CNT_W-1:0]          count_r;
  logic [wfsa_pkg::OWNER_W-1:0]        next_owner_r;
  logic [wfsa_pkg::DATA_W-1:0]         size_r;
  logic [wfsa_pkg::STATUS_W-1:0]       status_r;
  logic [AW-1:0]                       res_base_r;
  logic [wfsa_pkg::OWNER_W-1:0]        res_owner_r;
  logic [AW-1:0]                       ins_base_r;
  logic [wfsa_pkg::IDX_W-1:0]          pos_r;
  logic                                out_valid_r;
  logic [wfsa_pkg::STATUS_W-1:0]       out_status_r;
  logic [wfsa_pkg::DATA_W-1:0]         out_base_r;
  logic [wfsa_pkg::OWNER_W-1:0]        out_owner_r;

  logic                                in_xfer;
  logic                                cfg_we;
  logic                                out_load;
  logic                                grant;
  wfsa_pkg::bcast_t                    bc;
  wfsa_pkg::entry_t                    ent      [MS];
  wfsa_pkg::entry_t                    left_ent [MS];
  logic [AW-1:0]                       right_b  [MS];
  wfsa_pkg::tok_t                      tok      [MS+1];

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_we    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_RESERVED) ? reserved_r : total_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign grant     = tok[MS].found && (tok[MS].hole >= AW'(size_r));

  always_comb begin
    bc                 = '0;
    bc.total           = AW'(total_r);
    bc.count           = count_r;
    bc.ins_en          = (state_r == S_INS);
    bc.ins_pos         = pos_r;
    bc.ins_entry.base  = ins_base_r;
    bc.ins_entry.length = AW'(size_r);
    bc.ins_entry.owner = next_owner_r;
    bc.len0_we         = cfg_we && (cfg_paddr[2] == REG_RESERVED);
    bc.len0            = AW'(cfg_pwdata);
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_r == S_LAUNCH);
  end

  for (genvar i = 0; i < MS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_ent[i] = '0;
    end else begin : g_mid
      assign left_ent[i] = ent[i-1];
    end
    if (i == MS - 1) begin : g_last
      assign right_b[i] = '0;
    end else begin : g_inner
      assign right_b[i] = ent[i+1].base;
    end
    wfsa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (wfsa_pkg::IDX_W'(i)),
      .bc         (bc),
      .left_entry (left_ent[i]),
      .right_base (right_b[i]),
      .tok_in     (tok[i]),
      .entry      (ent[i]),
      .tok_out    (tok[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if ((reserved_r > total_r) || (in_request_size > total_r) ||
              (count_r == wfsa_pkg::CNT_W'(MS))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SET1;
          end
        end
      end
      S_SET1:   state_nxt = S_SET2;
      S_SET2:   state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_SCAN;
      S_SCAN: begin
        if (tok[MS].valid) begin
          state_nxt = grant ? S_INS : S_DONE;
        end
      end
      S_INS:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= wfsa_pkg::RESET_TOTAL;
      reserved_r   <= wfsa_pkg::RESET_RESERVED;
      count_r      <= wfsa_pkg::CNT_W'(1);
      next_owner_r <= wfsa_pkg::FIRST_OWNER;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_paddr[2] == REG_RESERVED) begin
          reserved_r <= cfg_pwdata;
        end else begin
          total_r <= cfg_pwdata;
        end
      end
      if (state_r == S_INS) begin
        count_r      <= count_r + wfsa_pkg::CNT_W'(1);
        next_owner_r <= next_owner_r + wfsa_pkg::OWNER_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      size_r      <= in_request_size;
      res_base_r  <= '0;
      res_owner_r <= '0;
      if (reserved_r > total_r) begin
        status_r <= wfsa_pkg::ST_BAD_CFG;
      end else if (in_request_size > total_r) begin
        status_r <= wfsa_pkg::ST_TOO_BIG;
      end else begin
        status_r <= wfsa_pkg::ST_FULL;
      end
    end
    if ((state_r == S_SCAN) && tok[MS].valid) begin
      status_r   <= wfsa_pkg::ST_NO_FIT;
      ins_base_r <= tok[MS].seg_end;
      pos_r      <= tok[MS].idx + wfsa_pkg::IDX_W'(1);
    end
    if (state_r == S_INS) begin
      status_r    <= wfsa_pkg::ST_GRANTED;
      res_base_r  <= ins_base_r;
      res_owner_r <= next_owner_r;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_base_r   <= wfsa_pkg::DATA_W'(res_base_r);
      out_owner_r  <= res_owner_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_base_address = out_base_r;
  assign out_owner_id     = out_owner_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= wfsa_pkg::CNT_W'(1)) && (count_r <= wfsa_pkg::CNT_W'(MS)))
    else $error("segment count out of range");

  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MS].valid |-> (state_r == S_SCAN))
    else $error("scan token left the row outside the scan phase");

  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> (count_r == $past(count_r) + wfsa_pkg::CNT_W'(1)))
    else $error("insert did not grow the table");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != wfsa_pkg::ST_GRANTED)) |->
      ((out_base_r == '0) && (out_owner_r == '0)))
    else $error("rejected transfer carries a base or an owner");
`endif

endmodule
